FILE: design/gbd_pkg.sv
package gbd_pkg;

	// vertex fields are four bits wide
	localparam int VTX_W = 4;
	localparam int VTX_N = 16;

	localparam int NUM_VERTICES_DEF = 16;
	localparam int MAX_DEGREE_DEF   = 16;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_REM = 2'd1;
	localparam logic [1:0] OP_BFS = 2'd2;
	localparam logic [1:0] OP_DFS = 2'd3;

	// datapath micro-operations
	typedef enum logic [4:0] {
		U_NOP,
		U_LOAD,
		U_A_SNAP,
		U_A_FULL,
		U_A_GO,
		U_A_W1,
		U_A_W2,
		U_R_LEN,
		U_R_RD,
		U_R_SHRD,
		U_R_SHW,
		U_R_SHDONE,
		U_R_SIDE,
		U_B_POP,
		U_B_CUR,
		U_B_EMIT,
		U_B_RD,
		U_B_NB,
		U_D_RD,
		U_D_POP,
		U_D_FRAME,
		U_D_PUSH,
		U_DONE
	} uop_t;

	typedef struct packed {
		logic [1:0] in_op;
		logic       in_ok;
		logic       full;
		logic       idx_zero;
		logic       match;
		logic       sh_more;
		logic       side_next;
		logic       q_empty;
		logic       nb_new;
		logic       top_more;
		logic       sp_last;
		logic       out_free;
		logic       emit_ok;
	} dp_stat_t;

endpackage

FILE: design/gbd_dp.sv
module gbd_dp #(
	parameter int NUM_VERTICES = gbd_pkg::NUM_VERTICES_DEF,
	parameter int MAX_DEGREE   = gbd_pkg::MAX_DEGREE_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  gbd_pkg::uop_t           uop,
	output gbd_pkg::dp_stat_t       stat,
	input  logic [1:0]              opcode,
	input  logic [gbd_pkg::VTX_W-1:0] src_vertex,
	input  logic [gbd_pkg::VTX_W-1:0] dest_vertex,
	input  logic                    directed,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [gbd_pkg::VTX_W-1:0] visit_vertex,
	output logic                    last_in_run,
	output logic                    status
);
	import gbd_pkg::*;

	localparam int IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
	localparam int DW = $clog2(MAX_DEGREE + 1);
	localparam int AW = VTX_W + IW;
	localparam int PW = $clog2(VTX_N + 1);
	localparam int SW = VTX_W + DW;
	localparam logic [DW+1:0] MDW = (DW+2)'(MAX_DEGREE);

	logic [VTX_W-1:0] s_q, d_q, cur_q, tgt_q, pend_v_q;
	logic             dir_q, second_q, st_q, pend_valid_q;
	logic [DW-1:0]    n_q, idx_q, pos_q;
	logic [PW-1:0]    head_q, tail_q, sp_q;
	logic [VTX_N-1:0] visited_q;
	logic [DW-1:0]    deg_q [VTX_N];
	logic             out_valid_q, last_q, status_q;
	logic [VTX_W-1:0] vv_q;

	logic [VTX_W-1:0] mem [2**AW];
	logic [VTX_W-1:0] mem_rd_q;
	logic [VTX_W-1:0] queue [VTX_N];
	logic [VTX_W-1:0] q_rd_q;
	logic [SW-1:0]    stack [VTX_N];
	logic [SW-1:0]    stk_rd_q;

	logic [DW-1:0]    deg_rd;
	logic             out_free, nb_new;
	logic             mem_we, mem_re;
	logic [AW-1:0]    mem_wa, mem_ra;
	logic [VTX_W-1:0] mem_wd;
	logic [DW-1:0]    d_idx;
	logic             full;
	logic             emit;

	assign deg_rd   = deg_q[cur_q];
	assign out_free = !out_valid_q || !out_stall;
	assign nb_new   = !visited_q[mem_rd_q];
	assign d_idx    = deg_rd - DW'(1) - pos_q;
	// micro-ops that load the output register
	assign emit     = ((uop == U_B_EMIT) && pend_valid_q) || (uop == U_D_PUSH) ||
	                  (uop == U_DONE);

	always_comb begin
		if (dir_q)
			full = ({2'b00, n_q} + (DW+2)'(1)) > MDW;
		else if (s_q == d_q)
			full = ({2'b00, n_q} + (DW+2)'(2)) > MDW;
		else
			full = (({2'b00, n_q} + (DW+2)'(1)) > MDW) ||
			       (({2'b00, deg_rd} + (DW+2)'(1)) > MDW);
	end

	always_comb begin
		stat.in_op     = opcode;
		stat.in_ok     = (int'(src_vertex) < NUM_VERTICES) &&
		                 ((opcode == OP_BFS) || (opcode == OP_DFS) ||
		                  (int'(dest_vertex) < NUM_VERTICES));
		stat.full      = full;
		stat.idx_zero  = (idx_q == '0);
		stat.match     = (mem_rd_q == tgt_q);
		stat.sh_more   = ({1'b0, idx_q} + (DW+1)'(1)) < {1'b0, n_q};
		stat.side_next = !dir_q && !second_q;
		stat.q_empty   = (head_q == tail_q);
		stat.nb_new    = nb_new;
		stat.top_more  = pos_q < deg_rd;
		stat.sp_last   = (sp_q == PW'(1));
		stat.out_free  = out_free;
		stat.emit_ok   = !pend_valid_q || out_free;
	end

	// adjacency store port selection
	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_wa = {cur_q, deg_rd[IW-1:0]};
		mem_ra = {cur_q, idx_q[IW-1:0]};
		mem_wd = d_q;
		case (uop)
			U_A_W1: begin
				mem_we = 1'b1;
			end
			U_A_W2: begin
				mem_we = 1'b1;
				mem_wd = s_q;
			end
			U_R_RD, U_B_RD: begin
				mem_re = 1'b1;
				mem_ra = {cur_q, IW'(idx_q - DW'(1))};
			end
			U_R_SHRD: begin
				mem_re = 1'b1;
				mem_ra = {cur_q, IW'(idx_q + DW'(1))};
			end
			U_R_SHW: begin
				mem_we = 1'b1;
				mem_wa = {cur_q, idx_q[IW-1:0]};
				mem_wd = mem_rd_q;
			end
			U_D_RD: begin
				mem_re = 1'b1;
				mem_ra = {cur_q, d_idx[IW-1:0]};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re)
			mem_rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk) begin
		if (uop == U_LOAD)
			queue[0] <= src_vertex;
		else if (uop == U_B_NB && nb_new)
			queue[tail_q[VTX_W-1:0]] <= mem_rd_q;
		if (uop == U_B_POP)
			q_rd_q <= queue[head_q[VTX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (uop == U_D_PUSH)
			stack[VTX_W'(sp_q - PW'(1))] <= {cur_q, pos_q};
		if (uop == U_D_POP)
			stk_rd_q <= stack[VTX_W'(sp_q - PW'(2))];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VTX_N; i++)
				deg_q[i] <= '0;
			visited_q    <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			sp_q         <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			s_q <= '0; d_q <= '0; cur_q <= '0; tgt_q <= '0; pend_v_q <= '0;
			dir_q <= 1'b0; second_q <= 1'b0; st_q <= 1'b0;
			n_q <= '0; idx_q <= '0; pos_q <= '0;
			vv_q <= '0; last_q <= 1'b0; status_q <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (uop)
				U_LOAD: begin
					s_q          <= src_vertex;
					d_q          <= dest_vertex;
					dir_q        <= directed;
					cur_q        <= src_vertex;
					tgt_q        <= dest_vertex;
					second_q     <= 1'b0;
					st_q         <= 1'b0;
					head_q       <= '0;
					tail_q       <= PW'(1);
					sp_q         <= PW'(1);
					pos_q        <= '0;
					visited_q    <= VTX_N'(1) << src_vertex;
					// out-of-range start reports vertex zero
					pend_v_q     <= (opcode == OP_DFS && stat.in_ok) ? src_vertex : '0;
					pend_valid_q <= (opcode == OP_DFS);
				end
				U_A_SNAP: begin
					n_q   <= deg_rd;
					cur_q <= d_q;
				end
				U_A_FULL: st_q <= 1'b1;
				U_A_GO:   cur_q <= s_q;
				U_A_W1: begin
					deg_q[cur_q] <= deg_rd + DW'(1);
					cur_q        <= d_q;
				end
				U_A_W2: deg_q[cur_q] <= deg_rd + DW'(1);
				U_R_LEN: begin
					idx_q <= deg_rd;
					n_q   <= deg_rd;
				end
				U_R_RD, U_B_RD: idx_q <= idx_q - DW'(1);
				U_R_SHW:    idx_q <= idx_q + DW'(1);
				U_R_SHDONE: deg_q[cur_q] <= n_q - DW'(1);
				U_R_SIDE: begin
					second_q <= 1'b1;
					cur_q    <= d_q;
					tgt_q    <= s_q;
				end
				U_B_CUR: begin
					cur_q  <= q_rd_q;
					head_q <= head_q + PW'(1);
				end
				U_B_EMIT: begin
					if (pend_valid_q) begin
						vv_q        <= pend_v_q;
						last_q      <= 1'b0;
						status_q    <= 1'b0;
					end
					pend_v_q     <= cur_q;
					pend_valid_q <= 1'b1;
					idx_q        <= deg_rd;
				end
				U_B_NB: begin
					if (nb_new) begin
						visited_q[mem_rd_q] <= 1'b1;
						tail_q              <= tail_q + PW'(1);
					end
				end
				U_D_RD:  pos_q <= pos_q + DW'(1);
				U_D_POP: sp_q  <= sp_q - PW'(1);
				U_D_FRAME: begin
					cur_q <= stk_rd_q[SW-1 -: VTX_W];
					pos_q <= stk_rd_q[DW-1:0];
				end
				U_D_PUSH: begin
					visited_q[mem_rd_q] <= 1'b1;
					cur_q       <= mem_rd_q;
					pos_q       <= '0;
					sp_q        <= sp_q + PW'(1);
					vv_q        <= pend_v_q;
					last_q      <= 1'b0;
					status_q    <= 1'b0;
					pend_v_q    <= mem_rd_q;
				end
				U_DONE: begin
					vv_q        <= pend_v_q;
					last_q      <= 1'b1;
					status_q    <= st_q;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign visit_vertex = vv_q;
	assign last_in_run  = last_q;
	assign status       = status_q;

endmodule

FILE: design/gbd_ctrl.sv
module gbd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  gbd_pkg::dp_stat_t stat,
	output gbd_pkg::uop_t     uop
);
	import gbd_pkg::*;

	typedef enum logic [19:0] {
		S_IDLE    = 20'd1 << 0,
		S_A_CHK1  = 20'd1 << 1,
		S_A_CHK2  = 20'd1 << 2,
		S_A_W1    = 20'd1 << 3,
		S_A_W2    = 20'd1 << 4,
		S_R_LEN   = 20'd1 << 5,
		S_R_SCAN  = 20'd1 << 6,
		S_R_CMP   = 20'd1 << 7,
		S_R_SHR   = 20'd1 << 8,
		S_R_SHW   = 20'd1 << 9,
		S_R_NEXT  = 20'd1 << 10,
		S_B_POP   = 20'd1 << 11,
		S_B_CUR   = 20'd1 << 12,
		S_B_EMIT  = 20'd1 << 13,
		S_B_SCAN  = 20'd1 << 14,
		S_B_NB    = 20'd1 << 15,
		S_D_TOP   = 20'd1 << 16,
		S_D_NB    = 20'd1 << 17,
		S_D_FRAME = 20'd1 << 18,
		S_DONE    = 20'd1 << 19
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		uop     = U_NOP;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					uop = U_LOAD;
					if (!stat.in_ok)
						state_d = S_DONE;
					else case (stat.in_op)
						OP_ADD:  state_d = S_A_CHK1;
						OP_REM:  state_d = S_R_LEN;
						OP_BFS:  state_d = S_B_POP;
						default: state_d = S_D_TOP;
					endcase
				end
			end
			S_A_CHK1: begin
				uop     = U_A_SNAP;
				state_d = S_A_CHK2;
			end
			S_A_CHK2: begin
				if (stat.full) begin
					uop     = U_A_FULL;
					state_d = S_DONE;
				end else begin
					uop     = U_A_GO;
					state_d = S_A_W1;
				end
			end
			S_A_W1: begin
				uop     = U_A_W1;
				state_d = stat.side_next ? S_A_W2 : S_DONE;
			end
			S_A_W2: begin
				uop     = U_A_W2;
				state_d = S_DONE;
			end
			S_R_LEN: begin
				uop     = U_R_LEN;
				state_d = S_R_SCAN;
			end
			S_R_SCAN: begin
				if (stat.idx_zero)
					state_d = S_R_NEXT;
				else begin
					uop     = U_R_RD;
					state_d = S_R_CMP;
				end
			end
			S_R_CMP: state_d = stat.match ? S_R_SHR : S_R_SCAN;
			S_R_SHR: begin
				if (stat.sh_more) begin
					uop     = U_R_SHRD;
					state_d = S_R_SHW;
				end else begin
					uop     = U_R_SHDONE;
					state_d = S_R_NEXT;
				end
			end
			S_R_SHW: begin
				uop     = U_R_SHW;
				state_d = S_R_SHR;
			end
			S_R_NEXT: begin
				if (stat.side_next) begin
					uop     = U_R_SIDE;
					state_d = S_R_LEN;
				end else
					state_d = S_DONE;
			end
			S_B_POP: begin
				if (stat.q_empty)
					state_d = S_DONE;
				else begin
					uop     = U_B_POP;
					state_d = S_B_CUR;
				end
			end
			S_B_CUR: begin
				uop     = U_B_CUR;
				state_d = S_B_EMIT;
			end
			S_B_EMIT: begin
				if (stat.emit_ok) begin
					uop     = U_B_EMIT;
					state_d = S_B_SCAN;
				end
			end
			S_B_SCAN: begin
				if (stat.idx_zero)
					state_d = S_B_POP;
				else begin
					uop     = U_B_RD;
					state_d = S_B_NB;
				end
			end
			S_B_NB: begin
				uop     = U_B_NB;
				state_d = S_B_SCAN;
			end
			S_D_TOP: begin
				if (stat.top_more) begin
					uop     = U_D_RD;
					state_d = S_D_NB;
				end else if (stat.sp_last)
					state_d = S_DONE;
				else begin
					uop     = U_D_POP;
					state_d = S_D_FRAME;
				end
			end
			S_D_NB: begin
				if (!stat.nb_new)
					state_d = S_D_TOP;
				else if (stat.out_free) begin
					uop     = U_D_PUSH;
					state_d = S_D_TOP;
				end
			end
			S_D_FRAME: begin
				uop     = U_D_FRAME;
				state_d = S_D_TOP;
			end
			S_DONE: begin
				if (stat.out_free) begin
					uop     = U_DONE;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

FILE: design/graph_bfs_dfs_engine.sv
// Channel  Handshake           Payload
// in       in_valid/in_stall   opcode, src_vertex, dest_vertex, directed
// out      out_valid/out_stall visit_vertex, last_in_run, status
//
// Edge remove scans list entries and shifts the entries after a match, per
// side. Breadth-first and depth-first traversal speed is set by the
// single-port adjacency store read loop.
// Reset clears degree counts, visit map and control; no clearing pass.
// A held out_stall parks the sequencer at its next result.
module graph_bfs_dfs_engine #(
	parameter int NUM_VERTICES = gbd_pkg::NUM_VERTICES_DEF,
	parameter int MAX_DEGREE   = gbd_pkg::MAX_DEGREE_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                opcode,
	input  logic [gbd_pkg::VTX_W-1:0] src_vertex,
	input  logic [gbd_pkg::VTX_W-1:0] dest_vertex,
	input  logic                      directed,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [gbd_pkg::VTX_W-1:0] visit_vertex,
	output logic                      last_in_run,
	output logic                      status
);
	import gbd_pkg::*;

	// controller issues one micro-op a cycle; datapath reports flags back
	uop_t     uop;
	dp_stat_t stat;

	gbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.uop      (uop)
	);

	// adjacency store, degree counts, queue, stack and output register
	gbd_dp #(
		.NUM_VERTICES (NUM_VERTICES),
		.MAX_DEGREE   (MAX_DEGREE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.uop          (uop),
		.stat         (stat),
		.opcode       (opcode),
		.src_vertex   (src_vertex),
		.dest_vertex  (dest_vertex),
		.directed     (directed),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.visit_vertex (visit_vertex),
		.last_in_run  (last_in_run),
		.status       (status)
	);

	// one item at a time: an accepted item closes the input side
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in progress");

	// full flag only on the single result of an add
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> last_in_run && visit_vertex == '0)
		else $error("status set on a non-final or traversal result");

	// a final result returns the sequencer to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_in_run && !$past(out_valid && !out_stall) && $rose(out_valid)
		|-> !in_stall)
		else $error("final result issued while still busy");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the graph traversal engine.
// A local model of the adjacency store predicts every result; a checker
// process compares accepted results against the queue of expected ones.
module tb_top;
	import gbd_pkg::*;

	typedef struct packed {
		logic [VTX_W-1:0] vtx;
		logic             last;
		logic             st;
	} visit_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [1:0]       opcode;
	logic [VTX_W-1:0] src_vertex;
	logic [VTX_W-1:0] dest_vertex;
	logic             directed;
	logic             out_valid;
	logic             out_stall;
	logic [VTX_W-1:0] visit_vertex;
	logic             last_in_run;
	logic             status;

	graph_bfs_dfs_engine i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .src_vertex(src_vertex),
		.dest_vertex(dest_vertex), .directed(directed),
		.out_valid(out_valid), .out_stall(out_stall),
		.visit_vertex(visit_vertex), .last_in_run(last_in_run),
		.status(status)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// predictor state: adjacency lists, newest entry at the top index
	logic [VTX_W-1:0] adj_list [VTX_N][MAX_DEGREE_DEF];
	int               adj_deg  [VTX_N];
	visit_t           visits_due[$];
	int               errors;
	int               hold_off;   // long receiver hold-off, in cycles
	bit               rx_bursty;  // receiver stall pattern on/off

	// remove the newest matching entry, closing the gap
	function automatic void drop_match(int v, int t);
		int i;
		for (i = adj_deg[v] - 1; i >= 0; i--)
			if (int'(adj_list[v][i]) == t) begin
				for (int k = i; k + 1 < adj_deg[v]; k++)
					adj_list[v][k] = adj_list[v][k + 1];
				adj_deg[v]--;
				return;
			end
	endfunction

	// update the model for one item and queue the results it causes
	function automatic void predict_visits(logic [1:0] op, int s, int d, bit dir);
		bit               seen[VTX_N];
		int               order[$];
		int               fifo[$];
		int               stk_v[$];
		int               stk_p[$];
		int               cur, nb, top;
		bit               full;
		visit_t           r;
		r = '0;
		if (op == OP_ADD || op == OP_REM) begin
			if (op == OP_ADD) begin
				if (dir) full = adj_deg[s] + 1 > MAX_DEGREE_DEF;
				else if (s == d) full = adj_deg[s] + 2 > MAX_DEGREE_DEF;
				else full = adj_deg[s] + 1 > MAX_DEGREE_DEF ||
					adj_deg[d] + 1 > MAX_DEGREE_DEF;
				if (full) r.st = 1'b1;
				else begin
					adj_list[s][adj_deg[s]++] = VTX_W'(d);
					if (!dir) adj_list[d][adj_deg[d]++] = VTX_W'(s);
				end
			end else begin
				drop_match(s, d);
				if (!dir) drop_match(d, s);
			end
			r.last = 1'b1;
			visits_due.push_back(r);
			return;
		end
		foreach (seen[i]) seen[i] = 1'b0;
		seen[s] = 1'b1;
		if (op == OP_BFS) begin
			fifo.push_back(s);
			while (fifo.size() > 0) begin
				cur = fifo.pop_front();
				order.push_back(cur);
				for (int i = adj_deg[cur] - 1; i >= 0; i--) begin
					nb = int'(adj_list[cur][i]);
					if (!seen[nb]) begin
						seen[nb] = 1'b1;
						fifo.push_back(nb);
					end
				end
			end
		end else begin
			// preorder walk, newest neighbour first
			order.push_back(s);
			stk_v.push_back(s);
			stk_p.push_back(0);
			while (stk_v.size() > 0) begin
				top = stk_v.size() - 1;
				cur = stk_v[top];
				if (stk_p[top] < adj_deg[cur]) begin
					nb = int'(adj_list[cur][adj_deg[cur] - 1 - stk_p[top]]);
					stk_p[top]++;
					if (!seen[nb] && stk_v.size() < VTX_N) begin
						seen[nb] = 1'b1;
						order.push_back(nb);
						stk_v.push_back(nb);
						stk_p.push_back(0);
					end
				end else begin
					void'(stk_v.pop_back());
					void'(stk_p.pop_back());
				end
			end
		end
		foreach (order[k]) begin
			r.vtx  = VTX_W'(order[k]);
			r.last = (k == order.size() - 1);
			r.st   = 1'b0;
			visits_due.push_back(r);
		end
	endfunction

	// offer one item, sometimes after a random gap; model updated on acceptance
	task automatic send_item(logic [1:0] op, int s, int d, bit dir);
		if ($urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		src_vertex  <= VTX_W'(s);
		dest_vertex <= VTX_W'(d);
		directed    <= dir;
		do @(posedge clk); while (in_stall);
		predict_visits(op, s, d, dir);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (visits_due.size() > 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (50) @(posedge clk);
	endtask

	// receiver: bursty stalls, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_off > 0) begin
			out_stall <= 1'b1;
			hold_off  <= hold_off - 1;
		end else if (rx_bursty) begin
			out_stall <= ($urandom_range(0, 2) == 0);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// result checker
	always @(posedge clk) begin
		visit_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (visits_due.size() == 0) begin
				$error("unexpected result vtx=%0d", visit_vertex);
				errors++;
			end else begin
				e = visits_due.pop_front();
				if (visit_vertex !== e.vtx) begin
					$error("visit_vertex exp %0d got %0d", e.vtx, visit_vertex);
					errors++;
				end
				if (last_in_run !== e.last) begin
					$error("last_in_run exp %0d got %0d", e.last, last_in_run);
					errors++;
				end
				if (status !== e.st) begin
					$error("status exp %0d got %0d", e.st, status);
					errors++;
				end
			end
		end
	end

	// every opcode, self-loops, mirror and one-way edges, missing removes
	task automatic test_directed_ops();
		send_item(OP_BFS, 0, 0, 0);
		send_item(OP_DFS, 15, 15, 1);
		send_item(OP_REM, 3, 4, 0);
		send_item(OP_ADD, 0, 15, 0);
		send_item(OP_ADD, 15, 7, 1);
		send_item(OP_ADD, 7, 7, 0);
		send_item(OP_ADD, 7, 7, 1);
		send_item(OP_ADD, 0, 7, 0);
		send_item(OP_ADD, 0, 7, 0);
		send_item(OP_BFS, 0, 9, 1);
		send_item(OP_DFS, 0, 9, 0);
		send_item(OP_REM, 7, 7, 0);
		send_item(OP_REM, 0, 7, 1);
		send_item(OP_REM, 15, 7, 0);
		send_item(OP_BFS, 15, 0, 0);
		send_item(OP_DFS, 7, 0, 1);
		drain();
	endtask

	// fill list 5 to its limit, then overflow both ways
	task automatic test_list_full();
		for (int i = 0; i < MAX_DEGREE_DEF; i++)
			send_item(OP_ADD, 5, i, 1);
		send_item(OP_ADD, 5, 1, 1);
		send_item(OP_ADD, 2, 5, 0);
		send_item(OP_REM, 5, 1, 1);
		send_item(OP_ADD, 5, 5, 0);
		send_item(OP_ADD, 5, 6, 0);
		send_item(OP_DFS, 5, 0, 0);
		send_item(OP_BFS, 5, 0, 0);
		drain();
	endtask

	// long receiver hold-off while traversals keep arriving
	task automatic test_back_pressure();
		hold_off = 400;
		for (int i = 0; i < 8; i++)
			send_item(2'(OP_BFS + (i & 1)), i, 0, 0);
		drain();
	endtask

	// random mix: mostly edge churn with frequent traversals
	task automatic test_random_mix();
		int n;
		int w;
		logic [1:0] op;
		n = 0;
		rx_bursty = 1'b1;
		while (n < 330) begin
			w = $urandom_range(0, 9);
			op = (w < 4) ? OP_ADD : (w < 6) ? OP_REM : (w < 8) ? OP_BFS : OP_DFS;
			send_item(op, $urandom_range(0, 15), $urandom_range(0, 15),
				1'($urandom_range(0, 1)));
			n++;
			if (n % 80 == 0) rx_bursty = ~rx_bursty;
		end
		drain();
	endtask

	initial begin
		errors      = 0;
		hold_off    = 0;
		rx_bursty   = 1'b1;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		opcode      = OP_ADD;
		src_vertex  = '0;
		dest_vertex = '0;
		directed    = 1'b0;
		foreach (adj_deg[v]) adj_deg[v] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_ops();
		test_list_full();
		test_back_pressure();
		test_random_mix();
		if (errors == 0 && visits_due.size() == 0)
			$display("PASS graph_bfs_dfs_engine");
		else
			$display("FAIL graph_bfs_dfs_engine");
		$finish;
	end

	// watchdog: far beyond the slowest correct run
	initial begin
		#20ms;
		$display("FAIL graph_bfs_dfs_engine");
		$finish;
	end
endmodule

FILE: filelist.f
design/gbd_pkg.sv
design/gbd_dp.sv
design/gbd_ctrl.sv
design/graph_bfs_dfs_engine.sv
verif/tb_top.sv
